@@ rtl/iptm_pkg.sv @@
// shared types, constants and the prefix mask function for the prefix table match block
// no dependencies
package iptm_pkg;

    localparam int ENTRIES    = 16;
    localparam int ADDR_W     = 128;
    localparam int HALF_W     = 64;
    localparam int LEN_W      = 8;
    localparam int IDX_W      = 4;
    localparam int SLOT_W     = (ENTRIES > 16) ? $clog2(ENTRIES) : IDX_W;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 8;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [IDX_W-1:0]  entry_index;
        logic [HALF_W-1:0] addr_high;
        logic [HALF_W-1:0] addr_low;
        logic [LEN_W-1:0]  prefix_length;
        logic              entry_enable;
    } t_item;

    // top len bits set, len in 0..128
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

endpackage

@@ rtl/iptm_cell.sv @@
// one table slot of the prefix match chain: holds one entry and checks a passing lookup
// depends on iptm_pkg
module iptm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [iptm_pkg::SLOT_W-1:0] i_slot,
    input  logic                        i_vld,
    input  iptm_pkg::t_item             i_item,
    input  logic                        i_hit,
    output logic                        o_vld,
    output iptm_pkg::t_item             o_item,
    output logic                        o_hit
);
    import iptm_pkg::*;

    logic [HALF_W-1:0] r_high;
    logic [HALF_W-1:0] r_low;
    logic [LEN_W-1:0]  r_len;
    logic              r_valid;
    logic              r_vld;
    t_item             r_item;
    logic              r_hit;

    logic              n_hit;
    logic              n_wr;
    logic [LEN_W-1:0]  n_len;
    logic [ADDR_W-1:0] diff;

    always_comb begin
        diff  = ({i_item.addr_high, i_item.addr_low} ^ {r_high, r_low})
                & prefix_mask(r_len);
        n_hit = i_hit | (i_vld && i_item.func == FUNC_LOOKUP && r_valid && diff == '0);
        n_wr  = i_vld && i_item.func == FUNC_WRITE
                && SLOT_W'(i_item.entry_index) == i_slot;
        n_len = (i_item.prefix_length > MAX_LEN) ? MAX_LEN : i_item.prefix_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
            r_hit <= n_hit;
            if (n_wr) begin
                r_valid <= i_item.entry_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= i_item;
            if (n_wr) begin
                r_high <= i_item.addr_high;
                r_low  <= i_item.addr_low;
                r_len  <= n_len;
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
    assign o_hit  = r_hit;

endmodule

@@ rtl/ipv6_prefix_table_match_core.sv @@
// top level of the ipv6 prefix table match block: a chain of table slot cells
// depends on iptm_pkg and iptm_cell
//
// usage:
//   input stream (s_axis): one transfer is either a table write or an address lookup,
//   selected by s_axis_tuser (0 write, 1 lookup). the item travels down a chain of
//   ENTRIES cells, one cell per cycle when not stalled; each cell holds one table
//   slot, takes a write addressed to it and ors its match into the passing lookup's
//   hit flag. output stream (m_axis): one result per input item, in order; bit 0 of
//   m_axis_tdata is the match flag, always 0 for writes.
//   the item passes through the ENTRIES cell registers in order, and m_axis_tvalid
//   is the valid register of the last cell.
//   throughput: one item per cycle when not stalled; writes and lookups may be mixed
//   freely since items never overtake each other in the chain.
//   stall: the last cell is the output register; while a result waits, the whole
//   chain holds and s_axis_tready is low. ready is high whenever the output is
//   empty or being taken.
//   reset: all slots become invalid and the chain empties; no clearing pass.
module ipv6_prefix_table_match_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // entry_index[3:0], addr_high[67:4], addr_low[131:68],
    // prefix_length[139:132], entry_enable[140], zeros above
    input  logic [iptm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // func
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // matched[0], zeros above
    output logic [iptm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import iptm_pkg::*;

    logic  adv;
    t_item in_item;
    logic  c_vld  [0:ENTRIES];
    t_item c_item [0:ENTRIES];
    logic  c_hit  [0:ENTRIES];

    always_comb begin
        in_item.func          = t_func'(s_axis_tuser);
        in_item.entry_index   = s_axis_tdata[3:0];
        in_item.addr_high     = s_axis_tdata[67:4];
        in_item.addr_low      = s_axis_tdata[131:68];
        in_item.prefix_length = s_axis_tdata[139:132];
        in_item.entry_enable  = s_axis_tdata[140];
    end

    assign adv           = !c_vld[ENTRIES] || m_axis_tready;
    assign s_axis_tready = adv;

    assign c_vld[0]  = s_axis_tvalid && adv;
    assign c_item[0] = in_item;
    assign c_hit[0]  = 1'b0;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        iptm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_slot  (SLOT_W'(k)),
            .i_vld   (c_vld[k]),
            .i_item  (c_item[k]),
            .i_hit   (c_hit[k]),
            .o_vld   (c_vld[k+1]),
            .o_item  (c_item[k+1]),
            .o_hit   (c_hit[k+1])
        );
    end

    assign m_axis_tvalid = c_vld[ENTRIES];
    assign m_axis_tdata  = {(OUT_DATA_W-1)'(0), c_hit[ENTRIES]};

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_write_no_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && c_item[ENTRIES].func == FUNC_WRITE |-> !m_axis_tdata[0])
        else $error("write item reports a match");

    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(c_item[ENTRIES]))
        else $error("chain moved while the output was stalled");

endmodule
